// File: design/sbpm_pkg.sv
package sbpm_pkg;

  localparam int unsigned PAT_BYTES = 16;

  localparam logic [4:0]  SINCE_RESET = 5'd16;
  localparam logic [4:0]  SINCE_TOP   = 5'd31;
  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_MODE     = 2'd3
  } reg_addr_e;

  typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

  typedef struct packed {
    logic [31:0] total_matches;
    logic [31:0] match_offset;
    logic        is_match;
    logic        search_done;
  } res_t;

endpackage

// File: design/sbpm_cell.sv
module sbpm_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               clear_i,
  input  logic [7:0]         byte_i,
  input  logic [4:0]         len_i,
  input  sbpm_pkg::pat_bytes_t pat_i,
  output logic [7:0]         byte_o,
  output logic               match_o
);

  localparam logic [4:0] IDX_V = 5'(IDX);

  logic [7:0] byte_q, byte_d;
  logic [4:0] sel;
  logic       active;

  // cell k sees window byte k after the shift; it lines up with pattern byte len-1-k
  assign active  = IDX_V < len_i;
  assign sel     = len_i - IDX_V - 5'd1;
  assign match_o = !active || (byte_i == pat_i[sel[3:0]]);
  assign byte_o  = byte_q;

  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = '0;
    end else if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

// File: design/sbpm_obuf.sv
module sbpm_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbpm_pkg::res_t res_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_ready_i,
  output sbpm_pkg::res_t res_o
);

  logic [1:0]     cnt_q, cnt_d, cnt_left;
  sbpm_pkg::res_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic           pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign res_o   = slot0_q;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    slot0_d  = slot0_q;
    slot1_d  = slot1_q;
    cnt_left = cnt_q - {1'b0, pop};
    if (pop && cnt_q == 2'd2) begin
      slot0_d = slot1_q;
    end
    if (push_i) begin
      if (cnt_left == 2'd0) begin
        slot0_d = res_i;
      end else begin
        slot1_d = res_i;
      end
    end
    cnt_d = cnt_left + {1'b0, push_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop_ready_i) |-> !push_i) else $error("push into full buffer");
`endif

endmodule

// File: design/stream_byte_pattern_matcher.sv
// Results are registered in the output buffer before they reach the master side.
// Throughput: one byte per cycle unless the buffer is full; all cells compare in the same cycle.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset (async, active low) clears the window, counters and registers:
// pattern zero, length 1, overlapping mode.
module stream_byte_pattern_matcher #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // data_byte [7:0]
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // match_offset [31:0], total_matches [63:32]
  output logic [63:0] m_axis_tdata,
  // is_match [0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned NCELL = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
  localparam logic [4:0]  CAP   = 5'(NCELL);

  logic [63:0] pat_low_q, pat_high_q;
  logic [4:0]  pat_len_q;
  logic        mode_q;
  logic        cfg_wr;
  sbpm_pkg::reg_addr_e cfg_addr;

  logic [31:0] pos_q, pos_d;
  logic [4:0]  since_q, since_d, since_inc;
  logic [31:0] total_q, total_d;

  logic        in_acc, clear, full, saturated, pos_ok, hit, all_eq;
  logic [4:0]  eff_len;
  sbpm_pkg::pat_bytes_t pat;
  sbpm_pkg::res_t res, head;

  logic [NCELL:0][7:0] chain;
  logic [NCELL-1:0]    eq;

  // configuration port
  assign pready   = 1'b1;
  assign cfg_addr = sbpm_pkg::reg_addr_e'(paddr[4:3]);
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    case (cfg_addr)
      sbpm_pkg::REG_PAT_LOW:  prdata = pat_low_q;
      sbpm_pkg::REG_PAT_HIGH: prdata = pat_high_q;
      sbpm_pkg::REG_PAT_LEN:  prdata = {59'd0, pat_len_q};
      sbpm_pkg::REG_MODE:     prdata = {63'd0, mode_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= 5'd1;
      mode_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_addr)
        sbpm_pkg::REG_PAT_LOW:  pat_low_q  <= pwdata;
        sbpm_pkg::REG_PAT_HIGH: pat_high_q <= pwdata;
        sbpm_pkg::REG_PAT_LEN:  pat_len_q  <= pwdata[4:0];
        sbpm_pkg::REG_MODE:     mode_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign pat     = {pat_high_q, pat_low_q};
  assign eff_len = (pat_len_q == 5'd0) ? 5'd1 : ((pat_len_q > CAP) ? CAP : pat_len_q);

  // window cells
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign clear    = in_acc && s_axis_tlast;
  assign chain[0] = s_axis_tdata;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sbpm_cell #(.IDX(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .clear_i (clear),
      .byte_i  (chain[k]),
      .len_i   (eff_len),
      .pat_i   (pat),
      .byte_o  (chain[k+1]),
      .match_o (eq[k])
    );
  end

  // match decision and counters
  assign all_eq    = &eq;
  assign saturated = pos_q == sbpm_pkg::SAT32;
  assign pos_ok    = saturated || (({1'b0, pos_q} + 33'd1) >= {28'd0, eff_len});
  assign since_inc = (since_q < sbpm_pkg::SINCE_TOP) ? since_q + 5'd1 : since_q;
  assign hit       = all_eq && pos_ok && !(mode_q && since_inc < eff_len);

  always_comb begin
    pos_d   = pos_q;
    since_d = since_q;
    total_d = total_q;
    if (in_acc) begin
      if (!saturated) begin
        pos_d = pos_q + 32'd1;
      end
      since_d = since_inc;
      if (hit) begin
        since_d = 5'd0;
        if (total_q != sbpm_pkg::SAT32) begin
          total_d = total_q + 32'd1;
        end
      end
    end
    res.total_matches = total_d;
    res.is_match      = hit;
    res.search_done   = s_axis_tlast;
    res.match_offset  = !hit ? 32'd0 :
                        (saturated ? sbpm_pkg::SAT32 : pos_q - {27'd0, eff_len} + 32'd1);
    if (clear) begin
      pos_d   = '0;
      since_d = sbpm_pkg::SINCE_RESET;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      since_q <= sbpm_pkg::SINCE_RESET;
      total_q <= '0;
    end else begin
      pos_q   <= pos_d;
      since_q <= since_d;
      total_q <= total_d;
    end
  end

  // output buffer
  assign s_axis_tready = !full;

  sbpm_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && (hit || s_axis_tlast)),
    .res_i       (res),
    .full_o      (full),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .res_o       (head)
  );

  assign m_axis_tdata = {head.total_matches, head.match_offset};
  assign m_axis_tuser = head.is_match;
  assign m_axis_tlast = head.search_done;

`ifndef SYNTHESIS
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (pos_q == '0 && total_q == '0 && since_q == sbpm_pkg::SINCE_RESET))
    else $error("counters not cleared after last byte");
  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && hit && !s_axis_tlast) |=> (since_q == 5'd0 && total_q != '0))
    else $error("match not recorded");
  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc) |=> $stable(total_q) && $stable(pos_q))
    else $error("counters moved without an item");
  a_nonoverlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && hit && mode_q) |-> (since_inc >= eff_len))
    else $error("overlapping match in nonoverlap mode");
`endif

endmodule
